[rtl/dhfk_pkg.sv]
// Shared types, constants and tables for the DH forward kinematics chain.
package dhfk_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ANGLE_BITS = 16;
   localparam int TRIG_ITERATIONS = 16;
   localparam int ITER_W = $clog2(TRIG_ITERATIONS + 2);
   localparam int ZW = 34;
   localparam int XW = 34;
   localparam int SCW = FRAC_BITS + 2;
   localparam int DHW = 34;
   localparam int PW = 32 + SCW;
   localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] HALF_P = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);

   localparam logic [0:0] REQ_BASE = 1'b0;
   localparam logic [0:0] REQ_LINK = 1'b1;

   typedef struct packed {
      logic [0:0] req_type;
      logic [3:0] base_index;
      logic signed [31:0] base_value;
      logic first_link;
      logic signed [15:0] joint_angle;
      logic signed [31:0] link_offset;
      logic signed [15:0] link_twist;
      logic signed [31:0] link_length;
   } req_word_type;

   typedef struct packed {
      logic [1:0] row;
      logic [1:0] col;
      logic signed [31:0] entry_value;
      logic saturated;
      logic last_entry;
   } rsp_word_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0: v = ZW'(536870912);  5'd1: v = ZW'(316933406);
         5'd2: v = ZW'(167458907);  5'd3: v = ZW'(85004756);
         5'd4: v = ZW'(42667331);   5'd5: v = ZW'(21354465);
         5'd6: v = ZW'(10679838);   5'd7: v = ZW'(5340245);
         5'd8: v = ZW'(2670163);    5'd9: v = ZW'(1335087);
         5'd10: v = ZW'(667544);    5'd11: v = ZW'(333772);
         5'd12: v = ZW'(166886);    5'd13: v = ZW'(83443);
         5'd14: v = ZW'(41722);     5'd15: v = ZW'(20861);
         5'd16: v = ZW'(10430);     5'd17: v = ZW'(5215);
         5'd18: v = ZW'(2608);      5'd19: v = ZW'(1304);
         5'd20: v = ZW'(652);       5'd21: v = ZW'(326);
         5'd22: v = ZW'(163);       5'd23: v = ZW'(81);
         5'd24: v = ZW'(41);        5'd25: v = ZW'(20);
         5'd26: v = ZW'(10);        5'd27: v = ZW'(5);
         5'd28: v = ZW'(3);         5'd29: v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
      return (p + HALF_P) >>> FRAC_BITS;
   endfunction

endpackage

[rtl/dhfk_front.sv]
// Front end: input queue of words, base matrix writes and link dispatch.
module dhfk_front (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  dhfk_pkg::req_word_type req_word,
   output logic link_valid,
   input  logic link_take,
   output logic base_we,
   output dhfk_pkg::req_word_type link_word
);
   import dhfk_pkg::*;

   req_word_type q_ff [2];
   req_word_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic pop;
   req_word_type head;

   assign req_full = (cnt_ff == 2'd2);
   assign head = q_ff[rd_ff];
   assign link_word = head;
   assign link_valid = (cnt_ff != 2'd0) && (head.req_type == REQ_LINK);
   assign base_we = (cnt_ff != 2'd0) && (head.req_type == REQ_BASE);
   assign pop = base_we || (link_valid && link_take);

   always_comb begin
      q_in = q_ff;
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (req_push && !req_full) begin
         q_in[wr_ff] = req_word;
         wr_in = ~wr_ff;
      end
      if (pop) begin
         rd_in = ~rd_ff;
      end
      cnt_in = cnt_ff + {1'b0, req_push && !req_full} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
   end
endmodule

[rtl/dhfk_back.sv]
// Back end: CORDIC sine/cosine, DH matrix, sequential matrix product.
module dhfk_back (
   input  logic clock,
   input  logic reset,
   input  logic link_valid,
   output logic link_take,
   input  dhfk_pkg::req_word_type link_word,
   input  logic base_we,
   input  logic [3:0] base_idx,
   input  logic signed [31:0] base_val,
   output logic rsp_empty,
   input  logic rsp_pop,
   output dhfk_pkg::rsp_word_type rsp_word
);
   import dhfk_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_TRIG = 6'b000010, S_DH = 6'b000100,
      S_MUL = 6'b001000, S_OUT = 6'b010000, S_WAIT = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   logic signed [31:0] base_ff [12];
   logic signed [31:0] run_ff [12];
   logic signed [31:0] res_ff [12];
   logic signed [DHW-1:0] dh_ff [12];
   logic signed [XW-1:0] x_ff [2], y_ff [2];
   logic signed [ZW-1:0] z_ff [2];
   logic neg_ff [2];
   logic [ITER_W-1:0] it_ff;
   logic [3:0] ent_ff, dhi_ff;
   logic [1:0] k_ff;
   logic signed [63:0] acc_ff, prod_ff;
   logic pv_ff;
   logic signed [31:0] a_ff, d_ff;
   logic sat_ff [12];
   rsp_word_type out_ff;
   logic out_v_ff;
   logic signed [SCW-1:0] sc_ff [4];

   function automatic logic signed [ZW-1:0] phase(input logic signed [15:0] g);
      logic [31:0] ph;
      ph = {g, 16'd0} & ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
      return ZW'(signed'(ph));
   endfunction

   function automatic logic signed [63:0] rsh(input logic signed [XW-1:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      if (30 - FRAC_BITS == 0) return w;
      return (w + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   endfunction

   logic [1:0] r_cur, c_cur;
   logic signed [31:0] mop_a;
   logic signed [DHW-1:0] mop_b;
   logic signed [63:0] psum;
   logic signed [SCW-1:0] st_v, ct_v, sa_v, ca_v;
   logic signed [31:0] dh_opa;
   logic signed [SCW-1:0] dh_opb;
   logic signed [PW-1:0] dh_prod;
   logic signed [63:0] dh_rnd;
   logic acc_ov;
   assign r_cur = ent_ff[3:2];
   assign c_cur = ent_ff[1:0];
   assign mop_a = run_ff[{r_cur, k_ff}];
   assign mop_b = dh_ff[{k_ff, c_cur}];
   assign st_v = sc_ff[0]; assign ct_v = sc_ff[1];
   assign sa_v = sc_ff[2]; assign ca_v = sc_ff[3];
   assign link_take = (st_ff == S_IDLE) && link_valid;
   assign rsp_empty = !out_v_ff;
   assign rsp_word = out_ff;
   assign dh_prod = PW'(dh_opa) * PW'(dh_opb);
   assign dh_rnd = rnd(64'(dh_prod));
   assign acc_ov = (acc_ff > 64'sd2147483647) || (acc_ff < -64'sd2147483648);

   always_comb begin
      dh_opa = '0;
      dh_opb = '0;
      case (dhi_ff)
         4'd0: begin dh_opa = 32'(st_v); dh_opb = ca_v; end
         4'd1: begin dh_opa = 32'(st_v); dh_opb = sa_v; end
         4'd2: begin dh_opa = a_ff; dh_opb = ct_v; end
         4'd3: begin dh_opa = 32'(ct_v); dh_opb = ca_v; end
         4'd4: begin dh_opa = 32'(ct_v); dh_opb = sa_v; end
         4'd5: begin dh_opa = a_ff; dh_opb = st_v; end
         default: ;
      endcase
   end

   always_comb begin
      psum = acc_ff + rnd(prod_ff);
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (link_valid) st_in = S_TRIG;
         S_TRIG: if (it_ff == ITER_W'(TRIG_ITERATIONS + 1)) st_in = S_DH;
         S_DH: if (dhi_ff == 4'd11) st_in = S_MUL;
         S_MUL: if (ent_ff == 4'd11 && !pv_ff && k_ff == 2'd3) st_in = S_OUT;
         S_OUT: st_in = S_WAIT;
         S_WAIT: if (!out_v_ff || rsp_pop) st_in = (ent_ff == 4'd11) ? S_IDLE : S_OUT;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         for (int i = 0; i < 12; i++) begin
            base_ff[i] <= (i == 0 || i == 5 || i == 10) ? 32'(ONE) : '0;
            run_ff[i] <= (i == 0 || i == 5 || i == 10) ? 32'(ONE) : '0;
         end
      end else begin
         st_ff <= st_in;
         if (st_ff == S_WAIT && (!out_v_ff || rsp_pop)) out_v_ff <= 1'b1;
         else if (rsp_pop) out_v_ff <= 1'b0;
         if (base_we && base_idx < 4'd12) base_ff[base_idx] <= base_val;
         case (st_ff)
            S_IDLE: begin
               if (link_valid) begin
                  if (link_word.first_link) run_ff <= base_ff;
                  z_ff[0] <= phase(link_word.joint_angle);
                  z_ff[1] <= phase(link_word.link_twist);
                  a_ff <= link_word.link_length;
                  d_ff <= link_word.link_offset;
                  it_ff <= '0;
               end
            end
            S_TRIG: begin
               if (it_ff == '0) begin
                  for (int j = 0; j < 2; j++) begin
                     x_ff[j] <= GAIN_Q30;
                     y_ff[j] <= '0;
                     neg_ff[j] <= (z_ff[j] > (ZW'(1) <<< 30)) ||
                                  (z_ff[j] < -(ZW'(1) <<< 30));
                     if (z_ff[j] > (ZW'(1) <<< 30)) begin
                        z_ff[j] <= z_ff[j] - (ZW'(1) <<< 31);
                     end else if (z_ff[j] < -(ZW'(1) <<< 30)) begin
                        z_ff[j] <= z_ff[j] + (ZW'(1) <<< 31);
                     end
                  end
               end else if (it_ff != ITER_W'(TRIG_ITERATIONS + 1)) begin
                  for (int j = 0; j < 2; j++) begin
                     if (z_ff[j] >= 0) begin
                        x_ff[j] <= x_ff[j] - (y_ff[j] >>> (it_ff - 1'b1));
                        y_ff[j] <= y_ff[j] + (x_ff[j] >>> (it_ff - 1'b1));
                        z_ff[j] <= z_ff[j] - atan_entry(5'(it_ff - 1'b1));
                     end else begin
                        x_ff[j] <= x_ff[j] + (y_ff[j] >>> (it_ff - 1'b1));
                        y_ff[j] <= y_ff[j] - (x_ff[j] >>> (it_ff - 1'b1));
                        z_ff[j] <= z_ff[j] + atan_entry(5'(it_ff - 1'b1));
                     end
                  end
               end else begin
                  sc_ff[0] <= SCW'(rsh(neg_ff[0] ? -y_ff[0] : y_ff[0]));
                  sc_ff[1] <= SCW'(rsh(neg_ff[0] ? -x_ff[0] : x_ff[0]));
                  sc_ff[2] <= SCW'(rsh(neg_ff[1] ? -y_ff[1] : y_ff[1]));
                  sc_ff[3] <= SCW'(rsh(neg_ff[1] ? -x_ff[1] : x_ff[1]));
                  dhi_ff <= '0;
               end
               it_ff <= it_ff + 1'b1;
            end
            S_DH: begin
               // one DH product per cycle through the shared multiplier
               case (dhi_ff)
                  4'd0: dh_ff[1] <= DHW'(-dh_rnd);
                  4'd1: dh_ff[2] <= DHW'(dh_rnd);
                  4'd2: dh_ff[3] <= DHW'(dh_rnd);
                  4'd3: dh_ff[5] <= DHW'(dh_rnd);
                  4'd4: dh_ff[6] <= DHW'(-dh_rnd);
                  4'd5: dh_ff[7] <= DHW'(dh_rnd);
                  default: begin
                     dh_ff[0] <= DHW'(ct_v); dh_ff[4] <= DHW'(st_v); dh_ff[8] <= '0;
                     dh_ff[9] <= DHW'(sa_v); dh_ff[10] <= DHW'(ca_v);
                     dh_ff[11] <= DHW'(d_ff);
                  end
               endcase
               dhi_ff <= dhi_ff + 1'b1;
               ent_ff <= '0; k_ff <= '0; acc_ff <= '0; pv_ff <= 1'b0;
            end
            S_MUL: begin
               if (k_ff != 2'd3) begin
                  prod_ff <= 64'(mop_a) * 64'(mop_b);
                  pv_ff <= 1'b1;
                  k_ff <= k_ff + 1'b1;
                  if (pv_ff) acc_ff <= psum;
               end else if (pv_ff) begin
                  acc_ff <= psum + ((c_cur == 2'd3) ? 64'(run_ff[{r_cur, 2'd3}]) : 64'sd0);
                  pv_ff <= 1'b0;
               end else begin
                  if (acc_ff > 64'sd2147483647) begin
                     res_ff[ent_ff] <= 32'h7fffffff;
                  end else if (acc_ff < -64'sd2147483648) begin
                     res_ff[ent_ff] <= 32'h80000000;
                  end else begin
                     res_ff[ent_ff] <= 32'(acc_ff);
                  end
                  sat_ff[ent_ff] <= acc_ov;
                  acc_ff <= '0; k_ff <= '0;
                  ent_ff <= (ent_ff == 4'd11) ? 4'd0 : ent_ff + 1'b1;
               end
            end
            S_WAIT: begin
               if (!out_v_ff || rsp_pop) begin
                  out_ff.row <= ent_ff[3:2];
                  out_ff.col <= ent_ff[1:0];
                  out_ff.entry_value <= res_ff[ent_ff];
                  out_ff.saturated <= sat_ff[ent_ff];
                  out_ff.last_entry <= (ent_ff == 4'd11);
                  if (ent_ff == 4'd11) run_ff <= res_ff;
                  else ent_ff <= ent_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

[rtl/dh_forward_kinematics_chain_core.sv]
// DH forward kinematics chain: 3x4 base load, per-link DH product, twelve entries out.
// Base write: applied from the head of the input queue, no result.
// Link: dispatch, CORDIC sine/cosine, DH matrix build and the sequential matrix product,
// then twelve words out through the S_OUT and S_WAIT states, held while the receiver stalls.
// One link in flight; a two-word input queue.
// Synchronous reset sets base and running transforms to identity and empties queues.
module dh_forward_kinematics_chain_core (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic full,
   input  dhfk_pkg::req_word_type req_word,
   output logic empty,
   input  logic pop,
   output dhfk_pkg::rsp_word_type rsp_word
);
   import dhfk_pkg::*;

   logic link_valid, link_take, base_we;
   req_word_type link_word;

   dhfk_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(full),
      .req_word(req_word), .link_valid(link_valid), .link_take(link_take),
      .base_we(base_we), .link_word(link_word)
   );

   dhfk_back u_back (
      .clock(clock), .reset(reset), .link_valid(link_valid), .link_take(link_take),
      .link_word(link_word),
      .base_we(base_we),
      .base_idx(link_word.base_index), .base_val(link_word.base_value),
      .rsp_empty(empty), .rsp_pop(pop), .rsp_word(rsp_word)
   );
endmodule

[dv/tb_top.sv]
// Testbench for the DH forward kinematics chain: queue driver, predictor and result checker.
`timescale 1ns / 100ps

module tb_top;
   import dhfk_pkg::*;

   localparam int  LIMIT_CYCLES = 2000000;
   localparam int  DRAIN_CYCLES = 300;
   localparam int  LONG_HOLD = 800;
   localparam longint Q_ONE = 64'sd1 <<< FRAC_BITS;

   logic clock, reset, req_push, full, empty, pop;
   req_word_type req_word;
   rsp_word_type rsp_word;

   req_word_type pending_words[$];
   rsp_word_type expected_entries[$];
   longint base_tf[12];
   longint chain_tf[12];
   int errors = 0;
   int links_taken = 0;
   int send_gap = 0;
   int pop_hold = 0;
   bit long_hold_done = 0;
   int cycle_count = 0;

   dh_forward_kinematics_chain_core u_top (
      .clock(clock), .reset(reset), .req_push(req_push), .full(full),
      .req_word(req_word), .empty(empty), .pop(pop), .rsp_word(rsp_word)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_q(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return round_q(a * b, FRAC_BITS);
   endfunction

   task automatic trig(input logic [15:0] ang, output longint s, output longint c);
      logic [31:0] ph;
      longint z, x, y, nx;
      bit neg;
      ph = {ang, 16'h0} & ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
      z = longint'(signed'(ph));
      x = 652032874;
      y = 0;
      neg = 0;
      if (z > (64'sd1 <<< 30)) begin
         z -= 64'sd1 <<< 31;
         neg = 1;
      end else if (z < -(64'sd1 <<< 30)) begin
         z += 64'sd1 <<< 31;
         neg = 1;
      end
      for (int i = 0; i < TRIG_ITERATIONS && i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(atan_entry(5'(i)));
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(atan_entry(5'(i)));
         end
         x = nx;
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      c = round_q(x, 30 - FRAC_BITS);
      s = round_q(y, 30 - FRAC_BITS);
   endtask

   task automatic predict_link(input req_word_type w);
      longint st, ct, sa, ca, a, d, sum;
      longint dh[12];
      longint res[12];
      rsp_word_type e;
      if (w.req_type == REQ_BASE) begin
         if (w.base_index < 12) base_tf[w.base_index] = longint'(w.base_value);
         return;
      end
      if (w.first_link) chain_tf = base_tf;
      d = longint'(w.link_offset);
      a = longint'(w.link_length);
      trig(w.joint_angle, st, ct);
      trig(w.link_twist, sa, ca);
      dh = '{ct, -qmul(st, ca), qmul(st, sa), qmul(a, ct),
             st, qmul(ct, ca), -qmul(ct, sa), qmul(a, st),
             0, sa, ca, d};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            sum = 0;
            for (int k = 0; k < 3; k++) sum += qmul(chain_tf[r*4+k], dh[k*4+c]);
            if (c == 3) sum += chain_tf[r*4+3];
            e.saturated = 0;
            if (sum > 64'sd2147483647) begin
               sum = 64'sd2147483647;
               e.saturated = 1;
            end else if (sum < -64'sd2147483648) begin
               sum = -64'sd2147483648;
               e.saturated = 1;
            end
            res[r*4+c] = sum;
            e.row = 2'(r);
            e.col = 2'(c);
            e.entry_value = 32'(sum);
            e.last_entry = (r == 2 && c == 3);
            expected_entries.push_back(e);
         end
      end
      chain_tf = res;
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
      errors++;
   endtask

   function automatic req_word_type link(bit first, logic [15:0] th, logic [31:0] d,
                                         logic [15:0] al, logic [31:0] a);
      req_word_type w;
      w = '0;
      w.req_type = REQ_LINK;
      w.first_link = first;
      w.joint_angle = th;
      w.link_offset = d;
      w.link_twist = al;
      w.link_length = a;
      w.base_index = 4'($urandom);
      w.base_value = $urandom;
      return w;
   endfunction

   function automatic req_word_type base_wr(logic [3:0] idx, logic [31:0] v);
      req_word_type w;
      w = req_word_type'({$urandom, $urandom, $urandom, $urandom, 6'($urandom)});
      w.req_type = REQ_BASE;
      w.base_index = idx;
      w.base_value = v;
      return w;
   endfunction

   function automatic logic [31:0] rand_len();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   initial begin
      int n;
      // directed: link from reset identity, extreme angles and lengths
      pending_words.push_back(link(0, 16'h0000, 32'h0, 16'h0000, 32'h0001_0000));
      pending_words.push_back(link(0, 16'h7FFF, 32'h7FFF_FFFF, 16'h8000, 32'h8000_0000));
      pending_words.push_back(link(0, 16'h4000, 32'h8000_0000, 16'hC000, 32'h7FFF_FFFF));
      pending_words.push_back(link(0, 16'h4001, 32'h0002_0000, 16'hBFFF, 32'h0001_8000));
      for (int i = 0; i < 16; i++)
         pending_words.push_back(base_wr(4'(i), (i % 5 == 0) ? 32'(Q_ONE) :
                                  (i == 3 ? 32'h7FFF_FFFF : (i == 7 ? 32'h8000_0000 : 32'h0))));
      pending_words.push_back(link(1, 16'h8000, 32'hFFFF_FFFF, 16'h7FFF, 32'h0));
      pending_words.push_back(link(0, 16'h2000, 32'h7FFF_FFFF, 16'h2000, 32'h7FFF_FFFF));
      pending_words.push_back(link(1, 16'hFFFF, 32'h0, 16'h0001, 32'hFFFF_0000));
      // random: chains of links, base reloads, noise
      n = 0;
      while (n < 345) begin
         if ($urandom_range(0, 5) == 0) begin
            for (int k = $urandom_range(1, 12); k > 0; k--) begin
               if ($urandom_range(0, 3) == 0)
                  pending_words.push_back(base_wr(4'($urandom), $urandom));
               else
                  pending_words.push_back(base_wr(4'($urandom_range(0, 11)),
                     32'($signed($urandom_range(0, 2 << FRAC_BITS)) - (1 << FRAC_BITS))));
               n++;
            end
         end else begin
            for (int k = $urandom_range(1, 6); k > 0; k--) begin
               pending_words.push_back(link((k == 1) ? 1'b0 : ($urandom_range(0, 5) == 0),
                  16'($urandom), rand_len(), 16'($urandom), rand_len()));
               n++;
            end
         end
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 0;
         req_word <= '0;
      end else begin
         if (req_push && !full) begin
            predict_link(req_word);
            if (req_word.req_type == REQ_LINK) links_taken++;
         end
         if (!req_push || !full) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 0;
            end else if (pending_words.size() > 0) begin
               req_word <= pending_words.pop_front();
               req_push <= 1;
               send_gap = pick_gap();
            end else begin
               req_push <= 0;
            end
         end
      end
   end

   // receiver stalls, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         pop <= 0;
      end else if (pop_hold > 0) begin
         pop_hold--;
         pop <= 0;
      end else if (!long_hold_done && links_taken >= 30) begin
         long_hold_done = 1;
         pop_hold = LONG_HOLD;
         pop <= 0;
      end else if ($urandom_range(0, 99) < 8) begin
         pop_hold = pick_gap();
         pop <= 0;
      end else begin
         pop <= ($urandom_range(0, 3) != 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && pop && !empty) begin
         if (expected_entries.size() == 0) begin
            report("unexpected word", rsp_word.entry_value, 0);
         end else begin
            e = expected_entries.pop_front();
            if (rsp_word.row != e.row) report("row", rsp_word.row, e.row);
            if (rsp_word.col != e.col) report("col", rsp_word.col, e.col);
            if (rsp_word.entry_value != e.entry_value)
               report("entry_value", rsp_word.entry_value, e.entry_value);
            if (rsp_word.saturated != e.saturated)
               report("saturated", rsp_word.saturated, e.saturated);
            if (rsp_word.last_entry != e.last_entry)
               report("last_entry", rsp_word.last_entry, e.last_entry);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < 12; k++) begin
         base_tf[k] = (k == 0 || k == 5 || k == 10) ? Q_ONE : 0;
         chain_tf[k] = base_tf[k];
      end
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;
      do @(posedge clock);
      while (pending_words.size() > 0 || req_push || expected_entries.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_entries.size() > 0) begin
         $display("%0t %0d words never arrived", $time, expected_entries.size());
         errors++;
      end
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
